FILE: rtl/kclp_pkg.sv
// ----------------------------------------------------------------------------
// kclp_pkg
// Shared types and constants for the key click / long-press detector.
// ----------------------------------------------------------------------------
package kclp_pkg;

    // Fixed field widths of the frame and the result
    localparam int KEY_W           = 16;
    localparam int KEY_WORD_W      = 18;
    localparam int MOUSE_LEFT_BIT  = 16;
    localparam int MOUSE_RIGHT_BIT = 17;
    localparam int FLAG_W          = 18;
    localparam int TIME_W          = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    // Configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLICK_TIME = 2'd0,
        CFG_LONG_TIME  = 2'd1
    } t_cfg_index;

    localparam logic [TIME_W-1:0] CLICK_TIME_RST = 16'd5;
    localparam logic [TIME_W-1:0] LONG_TIME_RST  = 16'd100;

    // Flags one lane hands to the merge stage
    typedef struct packed {
        logic press;
        logic lng;
        logic click;
    } t_lane_flags;

    // Occupancy of the output skid stage
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_skid_status;

endpackage

FILE: rtl/kclp_lane.sv
// ----------------------------------------------------------------------------
// kclp_lane
// One key: saturating hold counter plus press, long and click flags.
// ----------------------------------------------------------------------------
module kclp_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_held,
    input  logic [kclp_pkg::TIME_W-1:0]  i_click_time,
    input  logic [kclp_pkg::TIME_W-1:0]  i_long_time,
    output kclp_pkg::t_lane_flags        o_flags_next
);

    // Compare on a width that holds both the count and the times
    localparam int CMP_W = (COUNT_WIDTH > kclp_pkg::TIME_W) ? COUNT_WIDTH : kclp_pkg::TIME_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic                   r_press;
    logic                   r_long;
    logic                   r_click;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       inc_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [CMP_W-1:0]       click_ext;
    logic [CMP_W-1:0]       long_ext;

    assign cnt_inc   = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign inc_ext   = CMP_W'(cnt_inc);
    assign cnt_ext   = CMP_W'(r_cnt);
    assign click_ext = CMP_W'(i_click_time);
    assign long_ext  = CMP_W'(i_long_time);

    always_comb begin
        if (i_held) begin
            n_cnt              = cnt_inc;
            o_flags_next.press = r_press | (inc_ext > click_ext);
            o_flags_next.lng   = r_long | (inc_ext > long_ext);
            o_flags_next.click = r_click;
        end else begin
            // release: report a click only for a hold strictly between the times
            n_cnt              = '0;
            o_flags_next.press = 1'b0;
            o_flags_next.lng   = 1'b0;
            o_flags_next.click = (cnt_ext > click_ext) && (cnt_ext < long_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_press <= 1'b0;
            r_long  <= 1'b0;
            r_click <= 1'b0;
        end else if (i_advance) begin
            r_cnt   <= n_cnt;
            r_press <= o_flags_next.press;
            r_long  <= o_flags_next.lng;
            r_click <= o_flags_next.click;
        end
    end

endmodule

FILE: rtl/kclp_merge.sv
// ----------------------------------------------------------------------------
// kclp_merge
// Gather lane flags into the result words and hold them in a skid stage.
// ----------------------------------------------------------------------------
module kclp_merge #(
    parameter int NUM_KEYS = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  kclp_pkg::t_lane_flags                i_lanes [NUM_KEYS],
    output logic                                 o_ready,
    output logic                                 o_tvalid,
    input  logic                                 i_tready,
    output logic [kclp_pkg::OUT_TDATA_W-1:0]     o_tdata,
    output kclp_pkg::t_skid_status               o_status
);

    localparam int FW = kclp_pkg::FLAG_W;
    // Keys that reach the result words
    localparam int NK = (NUM_KEYS < FW) ? NUM_KEYS : FW;

    logic [FW-1:0]                     press_w;
    logic [FW-1:0]                     long_w;
    logic [FW-1:0]                     click_w;
    logic [kclp_pkg::OUT_TDATA_W-1:0]  beat;
    logic                              r_main_valid;
    logic                              r_skid_valid;
    logic [kclp_pkg::OUT_TDATA_W-1:0]  r_main_data;
    logic [kclp_pkg::OUT_TDATA_W-1:0]  r_skid_data;
    logic                              pop;

    // Keys past the result width are dropped; missing keys read as zero
    always_comb begin
        press_w = '0;
        long_w  = '0;
        click_w = '0;
        for (int j = 0; j < NK; j++) begin
            press_w[j] = i_lanes[j].press;
            long_w[j]  = i_lanes[j].lng;
            click_w[j] = i_lanes[j].click;
        end
    end

    assign beat = {{(kclp_pkg::OUT_TDATA_W - 3*FW){1'b0}}, click_w, long_w, press_w};
    assign pop  = r_main_valid && i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_main_valid || pop) begin
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || pop) begin
            r_main_data <= r_skid_valid ? r_skid_data : beat;
        end
        if (i_push && !r_skid_valid) begin
            r_skid_data <= beat;
        end
    end

    assign o_ready             = !r_skid_valid;
    assign o_tvalid            = r_main_valid;
    assign o_tdata             = r_main_data;
    assign o_status.main_valid = r_main_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule

FILE: rtl/key_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// key_click_long_press_detector
// Per-key hold counters giving press, long-press and click flags per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_axis channel is one remote-control frame: 16 keyboard
//   bits plus left and right mouse buttons, 18 keys in all. Every beat gives
//   exactly one beat on m_axis carrying the press, long and click flag words.
//   One lane per key updates its hold counter on every accepted beat, all
//   lanes side by side; the merge stage packs their flags into the result.
//   Throughput is one frame per cycle while m_axis is not stalled: the lanes
//   and the skid stage take a new beat every clock; results are registered.
//   The cfg channel writes click_time (index 0) and long_time (index 1); it
//   is always ready and writes to other indexes are dropped. Write it only
//   while no frame is in flight.
//   Reset (synchronous, active low) zeroes all counters and flags, empties
//   the output stage and restores click_time = 5, long_time = 100.
//   When the receiver stalls, the result holds in the output register and one
//   more frame lands in the skid register; s_axis_tready then drops until the
//   receiver takes a beat.
// ----------------------------------------------------------------------------
module key_click_long_press_detector #(
    parameter int NUM_KEYS    = 18,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // frame input: [15:0] key_bits, [16] mouse_left, [17] mouse_right
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kclp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result: [17:0] press_flags, [35:18] long_flags, [53:36] click_flags
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [kclp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kclp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kclp_pkg::TIME_W-1:0]          i_cfg_data
);

    logic [kclp_pkg::TIME_W-1:0]     r_click_time;
    logic [kclp_pkg::TIME_W-1:0]     r_long_time;
    logic [kclp_pkg::KEY_WORD_W-1:0] key_word;
    logic                            in_beat;
    kclp_pkg::t_lane_flags           lane_flags [NUM_KEYS];
    kclp_pkg::t_skid_status          skid_status;

    assign o_cfg_ready = 1'b1;

    // Register file: only the two listed indexes take effect
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_time <= kclp_pkg::CLICK_TIME_RST;
            r_long_time  <= kclp_pkg::LONG_TIME_RST;
        end else if (i_cfg_valid) begin
            unique case (kclp_pkg::t_cfg_index'(i_cfg_index))
                kclp_pkg::CFG_CLICK_TIME: r_click_time <= i_cfg_data;
                kclp_pkg::CFG_LONG_TIME:  r_long_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the frame into one key word: keyboard low, mouse buttons above
    assign key_word = {s_axis_tdata[kclp_pkg::MOUSE_RIGHT_BIT],
                       s_axis_tdata[kclp_pkg::MOUSE_LEFT_BIT],
                       s_axis_tdata[kclp_pkg::KEY_W-1:0]};

    assign in_beat = s_axis_tvalid && s_axis_tready;

    // One lane per key; keys beyond the frame are never held
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic held;
        if (k < kclp_pkg::KEY_WORD_W) begin : g_in_frame
            assign held = key_word[k];
        end else begin : g_extra
            assign held = 1'b0;
        end

        kclp_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_advance    (in_beat),
            .i_held       (held),
            .i_click_time (r_click_time),
            .i_long_time  (r_long_time),
            .o_flags_next (lane_flags[k])
        );
    end

    kclp_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_beat),
        .i_lanes  (lane_flags),
        .o_ready  (s_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_status (skid_status)
    );

    // The skid register only fills behind a held output beat
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_status.skid_valid |-> skid_status.main_valid)
        else $error("skid stage full while output stage empty");

    // After every accepted frame the output holds a valid beat the next cycle
    a_beat_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> m_axis_tvalid)
        else $error("accepted frame produced no output beat");

    // A frame accepted under a stalled output lands in the skid register
    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && m_axis_tvalid && !m_axis_tready) |=> skid_status.skid_valid)
        else $error("frame lost while output stalled");

    // Input back-pressure only while both stages hold beats
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (skid_status.main_valid && skid_status.skid_valid))
        else $error("input stalled with room in the output stages");

endmodule
